@@ rtl/kmm_pkg.sv @@
package kmm_pkg;

   localparam int KMM_ROWS      = 8;
   localparam int KMM_COLS      = 16;
   localparam int KMM_SIDE_ROWS = 8;
   localparam int KMM_SIDE_COLS = 8;

   localparam int OP_W      = 2;
   localparam int KROW_W    = 3;
   localparam int KCOL_W    = 4;
   localparam int BYTE_W    = 8;
   localparam int ENT_ROW_W = KROW_W + 1;
   localparam int ENT_COL_W = KCOL_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE0_ROW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE0_COL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE1_ROW = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE1_COL = 2'd3;

   localparam logic [KROW_W-1:0] SIDE0_ROW_RESET = 3'd0;
   localparam logic [KCOL_W-1:0] SIDE0_COL_RESET = 4'd0;
   localparam logic [KROW_W-1:0] SIDE1_ROW_RESET = 3'd0;
   localparam logic [KCOL_W-1:0] SIDE1_COL_RESET = 4'd8;

   localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_DUMP  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [BYTE_W-1:0] RPT_KEY  = 8'h12;
   localparam logic [BYTE_W-1:0] RPT_DUMP = 8'h11;
   localparam logic [BYTE_W-1:0] RPT_END  = 8'hFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_KEY,
      KIND_DUMP,
      KIND_CLEAR
   } kmm_kind_type;

   typedef struct packed {
      kmm_kind_type           kind;
      logic [ENT_ROW_W-1:0]   row;
      logic [ENT_COL_W-1:0]   col;
      logic                   pressed;
   } kmm_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } kmm_q_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_MOD,
      ST_KEY_HDR,
      ST_KEY_COL,
      ST_KEY_ROW,
      ST_DUMP_HDR,
      ST_DUMP_BYTE,
      ST_DUMP_TAIL,
      ST_CLR_RD,
      ST_CLR_WR
   } kmm_state_type;

endpackage

@@ rtl/kmm_if.sv @@
interface kmm_req_if import kmm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic                side;
   logic [KROW_W-1:0]   key_row;
   logic [KCOL_W-1:0]   key_col;
   logic                pressed;

   modport source (output valid, operation, side, key_row, key_col, pressed, input ready);
   modport sink   (input valid, operation, side, key_row, key_col, pressed, output ready);
endinterface

interface kmm_rsp_if import kmm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

@@ rtl/kmm_front.sv @@
module kmm_front import kmm_pkg::*; #(
   parameter int ROWS = KMM_ROWS,
   parameter int COLS = KMM_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   kmm_req_if.sink                req_bus,
   input  kmm_q_status_type       q_status,
   output logic                   q_push,
   output kmm_entry_type          q_entry
);

   logic [KROW_W-1:0] s0_row_ff, s0_row_in;
   logic [KCOL_W-1:0] s0_col_ff, s0_col_in;
   logic [KROW_W-1:0] s1_row_ff, s1_row_in;
   logic [KCOL_W-1:0] s1_col_ff, s1_col_in;

   logic [KROW_W-1:0]    roff;
   logic [KCOL_W-1:0]    coff;
   logic [ENT_ROW_W-1:0] sum_row;
   logic [ENT_COL_W-1:0] sum_col;
   logic                 in_range;
   logic                 keep;

   always_comb begin
      s0_row_in = s0_row_ff;
      s0_col_in = s0_col_ff;
      s1_row_in = s1_row_ff;
      s1_col_in = s1_col_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SIDE0_ROW: s0_row_in = csr_write_data[KROW_W-1:0];
            CSR_SIDE0_COL: s0_col_in = csr_write_data[KCOL_W-1:0];
            CSR_SIDE1_ROW: s1_row_in = csr_write_data[KROW_W-1:0];
            CSR_SIDE1_COL: s1_col_in = csr_write_data[KCOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_row_ff <= SIDE0_ROW_RESET;
         s0_col_ff <= SIDE0_COL_RESET;
         s1_row_ff <= SIDE1_ROW_RESET;
         s1_col_ff <= SIDE1_COL_RESET;
      end else begin
         s0_row_ff <= s0_row_in;
         s0_col_ff <= s0_col_in;
         s1_row_ff <= s1_row_in;
         s1_col_ff <= s1_col_in;
      end
   end

   always_comb begin
      roff     = req_bus.side ? s1_row_ff : s0_row_ff;
      coff     = req_bus.side ? s1_col_ff : s0_col_ff;
      sum_row  = {1'b0, req_bus.key_row} + {1'b0, roff};
      sum_col  = {1'b0, req_bus.key_col} + {1'b0, coff};
      in_range = (32'(sum_row) < ROWS) && (32'(sum_col) < COLS);

      q_entry.row     = sum_row;
      q_entry.col     = sum_col;
      q_entry.pressed = req_bus.pressed;
      q_entry.kind    = KIND_KEY;
      keep            = 1'b0;
      unique case (req_bus.operation)
         OP_KEY: begin
            q_entry.kind = KIND_KEY;
            keep         = in_range;
         end
         OP_DUMP: begin
            q_entry.kind = KIND_DUMP;
            keep         = 1'b1;
         end
         OP_CLEAR: begin
            q_entry.kind = KIND_CLEAR;
            q_entry.row  = {1'b0, roff};
            q_entry.col  = {1'b0, coff};
            keep         = 1'b1;
         end
         OP_NONE: keep = 1'b0;
         default: keep = 1'b0;
      endcase
   end

   assign req_bus.ready = !q_status.full;
   assign q_push        = req_bus.valid && !q_status.full && keep;

endmodule

@@ rtl/kmm_queue.sv @@
module kmm_queue import kmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kmm_entry_type    push_entry,
   input  logic             pop,
   output kmm_entry_type    head,
   output kmm_q_status_type status
);

   kmm_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (32'(count_ff) == QUEUE_DEPTH);
   assign status.empty = (count_ff == '0);

endmodule

@@ rtl/kmm_back.sv @@
module kmm_back import kmm_pkg::*; #(
   parameter int ROWS      = KMM_ROWS,
   parameter int COLS      = KMM_COLS,
   parameter int SIDE_ROWS = KMM_SIDE_ROWS,
   parameter int SIDE_COLS = KMM_SIDE_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  kmm_q_status_type q_status,
   input  kmm_entry_type    q_head,
   output logic             q_pop,
   kmm_rsp_if.source        rsp_bus
);

   localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW        = $clog2(ROWS + SIDE_ROWS + 16);
   localparam int ROW_BYTES = (COLS + 7) / 8;
   localparam int ROW_W     = ROW_BYTES * 8;
   localparam int BW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   logic [COLS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [COLS-1:0] rd_data_ff;
   logic            rd_valid_ff;

   kmm_state_type   state_ff, state_in;
   kmm_entry_type   cur_ff, cur_in;
   logic [CW-1:0]   row_cnt_ff, row_cnt_in;
   logic [CW-1:0]   row_end_ff, row_end_in;
   logic [BW-1:0]   byte_cnt_ff, byte_cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              rd_en, wr_en;
   logic [RW-1:0]     rd_addr, wr_addr;
   logic [COLS-1:0]   wr_data;
   logic [COLS-1:0]   rd_row;
   logic [COLS-1:0]   key_mask, clr_mask;
   logic [ROW_W-1:0]  dump_word;
   logic [CW-1:0]     clr_sum, clr_end;
   logic              can_load;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_last;

   assign rd_row    = rd_valid_ff ? rd_data_ff : '0;
   assign dump_word = ROW_W'(rd_row);
   assign can_load  = !rsp_valid_ff || rsp_bus.ready;
   assign clr_sum   = CW'(q_head.row) + CW'(SIDE_ROWS);
   assign clr_end   = (clr_sum < CW'(ROWS)) ? clr_sum : CW'(ROWS);

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         key_mask[c] = (int'(cur_ff.col) == c);
         clr_mask[c] = (c >= int'(cur_ff.col)) && (c < int'(cur_ff.col) + SIDE_COLS);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      row_cnt_in  = row_cnt_ff;
      row_end_in  = row_end_ff;
      byte_cnt_in = byte_cnt_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = row_cnt_ff[RW-1:0];
      wr_en       = 1'b0;
      wr_addr     = RW'(cur_ff.row);
      wr_data     = rd_row;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               unique case (q_head.kind)
                  KIND_KEY: begin
                     rd_en    = 1'b1;
                     rd_addr  = RW'(q_head.row);
                     state_in = ST_KEY_MOD;
                  end
                  KIND_DUMP: state_in = ST_DUMP_HDR;
                  KIND_CLEAR: begin
                     row_cnt_in = CW'(q_head.row);
                     row_end_in = clr_end;
                     if (CW'(q_head.row) < clr_end) begin
                        state_in = ST_CLR_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_KEY_MOD: begin
            wr_en    = 1'b1;
            wr_data  = cur_ff.pressed ? (rd_row | key_mask) : (rd_row & ~key_mask);
            state_in = ST_KEY_HDR;
         end
         ST_KEY_HDR: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = RPT_KEY;
               state_in  = ST_KEY_COL;
            end
         end
         ST_KEY_COL: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = BYTE_W'(cur_ff.col);
               state_in  = ST_KEY_ROW;
            end
         end
         ST_KEY_ROW: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = BYTE_W'({cur_ff.row, cur_ff.pressed});
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DUMP_HDR: begin
            if (can_load) begin
               emit        = 1'b1;
               emit_byte   = RPT_DUMP;
               rd_en       = 1'b1;
               rd_addr     = '0;
               row_cnt_in  = '0;
               byte_cnt_in = '0;
               state_in    = ST_DUMP_BYTE;
            end
         end
         ST_DUMP_BYTE: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = BYTE_W'(dump_word >> (8 * int'(byte_cnt_ff)));
               if (byte_cnt_ff == BW'(ROW_BYTES - 1)) begin
                  byte_cnt_in = '0;
                  if (row_cnt_ff == CW'(ROWS - 1)) begin
                     state_in = ST_DUMP_TAIL;
                  end else begin
                     row_cnt_in = row_cnt_ff + 1'b1;
                     rd_en      = 1'b1;
                     rd_addr    = RW'(row_cnt_ff + 1'b1);
                  end
               end else begin
                  byte_cnt_in = byte_cnt_ff + 1'b1;
               end
            end
         end
         ST_DUMP_TAIL: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = RPT_END;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_CLR_RD: begin
            rd_en    = 1'b1;
            state_in = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            wr_en      = 1'b1;
            wr_addr    = row_cnt_ff[RW-1:0];
            wr_data    = rd_row & ~clr_mask;
            row_cnt_in = row_cnt_ff + 1'b1;
            state_in   = (row_cnt_ff + 1'b1 == row_end_ff) ? ST_IDLE : ST_CLR_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      row_cnt_ff  <= row_cnt_in;
      row_end_ff  <= row_end_in;
      byte_cnt_ff <= byte_cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.last     = rsp_last_ff;

endmodule

@@ rtl/key_matrix_merge_and_report_core.sv @@
// Merges key events from two keyboard halves into one ROWS by COLS key matrix and reports
// on a byte stream. The request side takes one beat per cycle while the two-entry queue in
// front of the sequencer has room; key events outside the matrix and unused operation codes
// are dropped there. A key event reads and then writes its matrix row and then yields
// three beats; a dump yields 2 + ROWS * ((COLS + 7) / 8) beats, eighteen with the default
// size, at one beat per cycle while the sink is ready, as set by the byte-wide report
// channel; a side disconnect reads and rewrites each cleared row and yields nothing. The
// matrix reads as all zero after reset through per-row valid flags; no clearing pass is needed.
// Offsets must be written through the register port only while the block is idle (unchecked).
module key_matrix_merge_and_report_core import kmm_pkg::*; #(
   parameter int ROWS      = KMM_ROWS,
   parameter int COLS      = KMM_COLS,
   parameter int SIDE_ROWS = KMM_SIDE_ROWS,
   parameter int SIDE_COLS = KMM_SIDE_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   kmm_req_if.sink                req_bus,
   kmm_rsp_if.source              rsp_bus
);

   kmm_q_status_type q_status;
   kmm_entry_type    q_entry;
   kmm_entry_type    q_head;
   logic             q_push;
   logic             q_pop;

   kmm_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   kmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   kmm_back #(
      .ROWS      (ROWS),
      .COLS      (COLS),
      .SIDE_ROWS (SIDE_ROWS),
      .SIDE_COLS (SIDE_COLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("Entry pushed into a full queue.");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("Entry popped from an empty queue.");

   a_unused_op_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.operation == OP_NONE) |-> !q_push)
      else $error("Unused operation code reached the queue.");

endmodule

@@ sim/tb_top.sv @@
module tb_top import kmm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_SETS  = 5;
   localparam int SET_ITEMS    = 20;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic              side;
      logic [KROW_W-1:0] key_row;
      logic [KCOL_W-1:0] key_col;
      logic              pressed;
   } key_request_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } report_beat_type;

   class key_report_board;
      logic [KMM_COLS-1:0] key_bits [KMM_ROWS];
      logic [KROW_W-1:0]   row_offset [2];
      logic [KCOL_W-1:0]   col_offset [2];
      report_beat_type     due_beats [$];
      int                  op_count [4];
      int                  errors;
      int                  beats_checked;

      function new();
         foreach (key_bits[r]) key_bits[r] = '0;
         foreach (op_count[i]) op_count[i] = 0;
         row_offset[0] = SIDE0_ROW_RESET;
         col_offset[0] = SIDE0_COL_RESET;
         row_offset[1] = SIDE1_ROW_RESET;
         col_offset[1] = SIDE1_COL_RESET;
         errors        = 0;
         beats_checked = 0;
      endfunction

      function void write_offset(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SIDE0_ROW: row_offset[0] = data[KROW_W-1:0];
            CSR_SIDE0_COL: col_offset[0] = data[KCOL_W-1:0];
            CSR_SIDE1_ROW: row_offset[1] = data[KROW_W-1:0];
            CSR_SIDE1_COL: col_offset[1] = data[KCOL_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_beat(logic [BYTE_W-1:0] out_byte, logic last);
         report_beat_type beat;
         beat.out_byte = out_byte;
         beat.last     = last;
         due_beats.push_back(beat);
      endfunction

      function void note_request(key_request_type item);
         logic [ENT_ROW_W-1:0] row;
         logic [ENT_COL_W-1:0] col;
         int                   r_first;
         int                   c_first;
         op_count[item.operation]++;
         row     = {1'b0, item.key_row} + row_offset[item.side];
         col     = {1'b0, item.key_col} + col_offset[item.side];
         r_first = int'(row_offset[item.side]);
         c_first = int'(col_offset[item.side]);
         case (item.operation)
            OP_KEY: begin
               if (row < KMM_ROWS && col < KMM_COLS) begin
                  key_bits[row[KROW_W-1:0]][col[KCOL_W-1:0]] = item.pressed;
                  push_beat(RPT_KEY, 1'b0);
                  push_beat(BYTE_W'(col), 1'b0);
                  push_beat(BYTE_W'({row, item.pressed}), 1'b1);
               end
            end
            OP_DUMP: begin
               push_beat(RPT_DUMP, 1'b0);
               for (int r = 0; r < KMM_ROWS; r++) begin
                  for (int b = 0; b < (KMM_COLS + 7) / 8; b++) begin
                     push_beat(key_bits[r][8*b +: 8], 1'b0);
                  end
               end
               push_beat(RPT_END, 1'b1);
            end
            OP_CLEAR: begin
               for (int r = r_first; r < r_first + KMM_SIDE_ROWS && r < KMM_ROWS; r++) begin
                  for (int c = c_first; c < c_first + KMM_SIDE_COLS && c < KMM_COLS; c++) begin
                     key_bits[r][c] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_beat(logic [BYTE_W-1:0] out_byte, logic last);
         report_beat_type want;
         beats_checked++;
         if (due_beats.size() == 0) begin
            if (errors < 50)
               $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                        $time, out_byte, last);
            errors++;
         end else begin
            want = due_beats.pop_front();
            if (out_byte !== want.out_byte) begin
               if (errors < 50)
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.out_byte, out_byte);
               errors++;
            end
            if (last !== want.last) begin
               if (errors < 50)
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, last);
               errors++;
            end
         end
      endfunction

      function int pending();
         return due_beats.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   kmm_req_if req_bus ();
   kmm_rsp_if rsp_bus ();

   key_report_board board = new();

   bit snd_idle     = 1'b1;
   bit rsp_idle     = 1'b1;
   int long_hold    = 0;
   int cycle_count  = 0;
   int settings_run = 1;

   key_matrix_merge_and_report_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run timed out with %0d beats still due", $time, board.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Report sink: while rsp_idle is set every beat draws its own stall, and a long hold-off can be requested.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = rsp_idle ? $urandom_range(0, 15) : 0;
         if (long_hold > 0) begin
            stall     = long_hold;
            long_hold = 0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_beat(rsp_bus.out_byte, rsp_bus.last);
      end
   end

   function automatic key_request_type make_request(logic [OP_W-1:0] operation, logic side,
                                                    logic [KROW_W-1:0] key_row,
                                                    logic [KCOL_W-1:0] key_col,
                                                    logic pressed);
      key_request_type item;
      item.operation = operation;
      item.side      = side;
      item.key_row   = key_row;
      item.key_col   = key_col;
      item.pressed   = pressed;
      return item;
   endfunction

   // Most key events are aimed inside the matrix so that the reports carry real content.
   function automatic key_request_type random_request();
      key_request_type item;
      int              pick;
      pick = $urandom_range(0, 99);
      item = make_request(OP_KEY, 1'($urandom_range(0, 1)), KROW_W'($urandom_range(0, 7)),
                          KCOL_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      if (pick < 60) begin
         if ($urandom_range(0, 9) < 7) begin
            item.key_row = KROW_W'($urandom_range(0,
                                   KMM_ROWS - 1 - board.row_offset[item.side]));
            item.key_col = KCOL_W'($urandom_range(0,
                                   KMM_COLS - 1 - board.col_offset[item.side]));
         end
      end else if (pick < 75) begin
         item.operation = OP_DUMP;
      end else if (pick < 90) begin
         item.operation = OP_CLEAR;
      end else begin
         item.operation = OP_NONE;
      end
      return item;
   endfunction

   task automatic send_request(key_request_type item);
      int gap;
      gap = snd_idle ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= item.operation;
      req_bus.side      <= item.side;
      req_bus.key_row   <= item.key_row;
      req_bus.key_col   <= item.key_col;
      req_bus.pressed   <= item.pressed;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(item);
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      board.write_offset(index, data);
   endtask

   task automatic apply_offsets(logic [CSR_DATA_W-1:0] s0_row, logic [CSR_DATA_W-1:0] s0_col,
                                logic [CSR_DATA_W-1:0] s1_row, logic [CSR_DATA_W-1:0] s1_col);
      settle();
      write_register(CSR_SIDE0_ROW, s0_row);
      write_register(CSR_SIDE0_COL, s0_col);
      write_register(CSR_SIDE1_ROW, s1_row);
      write_register(CSR_SIDE1_COL, s1_col);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_run++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_offset(int top);
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return '0;
      if (pick == 1) return CSR_DATA_W'(top);
      return CSR_DATA_W'($urandom_range(0, 15));
   endfunction

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_KEY;
      req_bus.side      = 1'b0;
      req_bus.key_row   = '0;
      req_bus.key_col   = '0;
      req_bus.pressed   = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset offsets: corners of both halves, a column past the edge, an unused code.
      send_request(make_request(OP_DUMP, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_KEY, 1'b0, 3'd0, 4'd0, 1'b1));
      send_request(make_request(OP_KEY, 1'b1, 3'd7, 4'd7, 1'b1));
      send_request(make_request(OP_KEY, 1'b0, 3'd7, 4'd15, 1'b1));
      send_request(make_request(OP_KEY, 1'b1, 3'd0, 4'd8, 1'b1));
      send_request(make_request(OP_KEY, 1'b0, 3'd3, 4'd5, 1'b0));
      send_request(make_request(OP_NONE, 1'b1, 3'd7, 4'd15, 1'b1));
      send_request(make_request(OP_DUMP, 1'b1, 3'd7, 4'd15, 1'b1));
      send_request(make_request(OP_CLEAR, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_DUMP, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_CLEAR, 1'b1, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_DUMP, 1'b0, 3'd0, 4'd0, 1'b0));

      // Largest side 0 offsets, so the disconnect region is clipped to one key.
      apply_offsets(4'hF, 4'hF, 4'h8, 4'h0);
      send_request(make_request(OP_KEY, 1'b0, 3'd0, 4'd0, 1'b1));
      send_request(make_request(OP_KEY, 1'b0, 3'd1, 4'd0, 1'b1));
      send_request(make_request(OP_KEY, 1'b0, 3'd0, 4'd1, 1'b1));
      send_request(make_request(OP_KEY, 1'b1, 3'd7, 4'd15, 1'b1));
      send_request(make_request(OP_KEY, 1'b1, 3'd0, 4'd0, 1'b1));
      send_request(make_request(OP_KEY, 1'b1, 3'd5, 4'd10, 1'b1));
      send_request(make_request(OP_DUMP, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_CLEAR, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_DUMP, 1'b1, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_CLEAR, 1'b1, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_DUMP, 1'b0, 3'd0, 4'd0, 1'b0));
      send_request(make_request(OP_KEY, 1'b1, 3'd4, 4'd12, 1'b0));

      for (int set = 0; set < RANDOM_SETS; set++) begin
         apply_offsets(random_offset(7), random_offset(15), random_offset(7), random_offset(15));
         snd_idle = (set != 3);
         rsp_idle = (set != 3);
         if (set == 1) begin
            snd_idle  = 1'b0;
            long_hold = LONG_HOLD;
         end
         for (int i = 0; i < SET_ITEMS; i++) begin
            if (set == 1 && i == SET_ITEMS / 2) begin
               snd_idle = 1'b1;
               settle();
            end
            send_request(random_request());
         end
      end

      settle();
      $display("Covered %0d key events, %0d dumps, %0d disconnects and %0d unused codes",
               board.op_count[OP_KEY], board.op_count[OP_DUMP], board.op_count[OP_CLEAR],
               board.op_count[OP_NONE]);
      $display("over %0d offset settings; %0d report beats compared, %0d mismatches.",
               settings_run, board.beats_checked, board.errors);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
